>>> src/stp_pkg.sv
`timescale 1ns / 1ps

package stp_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int HASH_BYTES     = 32;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 5;

  // CompactSize prefixes
  localparam logic [7:0] VI_TAG16 = 8'hfd;
  localparam logic [7:0] VI_TAG32 = 8'hfe;
  localparam logic [7:0] VI_NONE  = 8'h00;

  typedef enum logic [16:0] {
    PH_VER    = 17'h00001,
    PH_FLAG   = 17'h00002,
    PH_INCNT  = 17'h00004,
    PH_TXID   = 17'h00008,
    PH_VOUT   = 17'h00010,
    PH_SIGLEN = 17'h00020,
    PH_SIG    = 17'h00040,
    PH_SEQ    = 17'h00080,
    PH_OUTCNT = 17'h00100,
    PH_VAL    = 17'h00200,
    PH_SPKLEN = 17'h00400,
    PH_SPK    = 17'h00800,
    PH_WITCNT = 17'h01000,
    PH_WITLEN = 17'h02000,
    PH_WIT    = 17'h04000,
    PH_LOCK   = 17'h08000,
    PH_DONE   = 17'h10000
  } phase_t;

  localparam logic [3:0] KIND_VERSION  = 4'd0;
  localparam logic [3:0] KIND_FLAG     = 4'd1;
  localparam logic [3:0] KIND_INCNT    = 4'd2;
  localparam logic [3:0] KIND_TXID     = 4'd3;
  localparam logic [3:0] KIND_VOUT     = 4'd4;
  localparam logic [3:0] KIND_SIGLEN   = 4'd5;
  localparam logic [3:0] KIND_SIGBYTE  = 4'd6;
  localparam logic [3:0] KIND_SEQ      = 4'd7;
  localparam logic [3:0] KIND_OUTCNT   = 4'd8;
  localparam logic [3:0] KIND_VALUE    = 4'd9;
  localparam logic [3:0] KIND_SPKLEN   = 4'd10;
  localparam logic [3:0] KIND_SPKBYTE  = 4'd11;
  localparam logic [3:0] KIND_WITCNT   = 4'd12;
  localparam logic [3:0] KIND_WITLEN   = 4'd13;
  localparam logic [3:0] KIND_WITBYTE  = 4'd14;
  localparam logic [3:0] KIND_LOCKTIME = 4'd15;

  localparam logic [2:0] ST_RUNNING     = 3'd0;
  localparam logic [2:0] ST_ACCEPTED    = 3'd1;
  localparam logic [2:0] ST_TRUNCATED   = 3'd2;
  localparam logic [2:0] ST_NONCANON    = 3'd3;
  localparam logic [2:0] ST_ZERO_FLAG   = 3'd4;
  localparam logic [2:0] ST_ZERO_INPUTS = 3'd5;
  localparam logic [2:0] ST_TRAILING    = 3'd6;
  localparam logic [2:0] ST_OVERSIZE    = 3'd7;

  typedef struct packed {
    logic        valid;
    logic [3:0]  kind;
    logic [63:0] value;
    logic [31:0] index;
    logic [2:0]  status;
  } result_t;

endpackage

>>> src/strict_transaction_parser.sv
`timescale 1ns / 1ps

// The result beat for a byte is registered and is on out_* in the cycle after that byte's beat is taken.
// Throughput: one byte per cycle while in_tready is high; a single pass of the phase/counter update logic per byte.
// in_tready stays high while the result register is empty or being drained this cycle.
// Reset: rst_n is synchronous, active low, and clears all parser state and out_tvalid.
// Parser state also returns to its reset values after every beat that carries in_tlast.

module strict_transaction_parser #(
  parameter int COUNT_BITS = stp_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [stp_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] data_byte
  input  logic                             in_tlast,   // last_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [stp_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [63:0] field_value,
                                                       // [95:64] item_index,
                                                       // [98:96] parse_status, rest zero
  output logic [stp_pkg::OUT_TUSER_W-1:0]  out_tuser   // [0] field_valid, [4:1] field_kind
);

  // Largest count or length the counters can hold.
  localparam logic [63:0]           CNT_MAX  = {64{1'b1}} >> (64 - COUNT_BITS);
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_ZERO = '0;
  localparam logic [5:0]            HASH_END = 6'(stp_pkg::HASH_BYTES - 1);

  // ---------------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------------
  stp_pkg::phase_t        phase_r, phase_nxt;
  logic [5:0]             cnt_r, cnt_nxt;         // bytes taken of the current field
  logic [63:0]            acc_r, acc_nxt;         // little-endian field accumulator
  logic [7:0]             tag_r, tag_nxt;         // CompactSize prefix, zero when none
  logic                   segwit_r, segwit_nxt;
  logic [COUNT_BITS-1:0]  in_total_r, in_total_nxt;
  logic [COUNT_BITS-1:0]  entries_r, entries_nxt;
  logic [COUNT_BITS-1:0]  stack_r, stack_nxt;
  logic [COUNT_BITS-1:0]  payload_r, payload_nxt;
  logic [COUNT_BITS-1:0]  cursor_r, cursor_nxt;
  logic [2:0]             err_r, err_nxt;

  stp_pkg::result_t       res_r, res_nxt;
  logic                   out_valid_r;

  logic in_acc;
  logic state_clr;

  // A new byte is taken whenever the result register is free or drains now.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign state_clr = !rst_n || (in_acc && in_tlast);

  // ---------------------------------------------------------------------------
  // Fixed-width little-endian field step
  // ---------------------------------------------------------------------------
  logic [63:0] byte_sh;
  logic [63:0] merged;
  logic [3:0]  fix_need;
  logic        fix_done;
  logic        is_varint;

  assign byte_sh = 64'(in_tdata) << {cnt_r[2:0], 3'b000};
  assign merged  = acc_r | byte_sh;

  assign is_varint = (phase_r == stp_pkg::PH_INCNT)  || (phase_r == stp_pkg::PH_SIGLEN) ||
                     (phase_r == stp_pkg::PH_OUTCNT) || (phase_r == stp_pkg::PH_SPKLEN) ||
                     (phase_r == stp_pkg::PH_WITCNT) || (phase_r == stp_pkg::PH_WITLEN);

  always_comb begin
    if (is_varint) begin
      if (tag_r == stp_pkg::VI_TAG16) begin
        fix_need = 4'd2;
      end else if (tag_r == stp_pkg::VI_TAG32) begin
        fix_need = 4'd4;
      end else begin
        fix_need = 4'd8;
      end
    end else if (phase_r == stp_pkg::PH_VAL) begin
      fix_need = 4'd8;
    end else begin
      fix_need = 4'd4;
    end
  end

  assign fix_done = (cnt_r + 6'd1) >= {2'b00, fix_need};

  // ---------------------------------------------------------------------------
  // CompactSize step: pending, done with a value, or rejected with a code
  // ---------------------------------------------------------------------------
  logic                  vi_done;
  logic                  vi_rej;
  logic [2:0]            vi_code;
  logic [63:0]           vi_val;
  logic [COUNT_BITS-1:0] vi_cnt;
  logic [7:0]            vi_tag_nxt;
  logic [5:0]            vi_cnt_nxt;
  logic [63:0]           vi_acc_nxt;
  logic                  vi_check;
  logic                  vi_canon;

  always_comb begin
    if (tag_r == stp_pkg::VI_TAG16) begin
      vi_canon = merged[15:0] >= {8'h00, stp_pkg::VI_TAG16};
    end else if (tag_r == stp_pkg::VI_TAG32) begin
      vi_canon = |merged[31:16];
    end else begin
      vi_canon = |merged[63:32];
    end
  end

  always_comb begin
    vi_done    = 1'b0;
    vi_rej     = 1'b0;
    vi_code    = stp_pkg::ST_RUNNING;
    vi_val     = merged;
    vi_tag_nxt = tag_r;
    vi_cnt_nxt = cnt_r + 6'd1;
    vi_acc_nxt = merged;
    vi_check   = 1'b0;
    if (tag_r == stp_pkg::VI_NONE) begin
      vi_cnt_nxt = 6'd0;
      vi_acc_nxt = 64'd0;
      if (in_tdata < stp_pkg::VI_TAG16) begin
        vi_val   = 64'(in_tdata);
        vi_check = 1'b1;
      end else begin
        vi_tag_nxt = in_tdata;
      end
    end else if (fix_done) begin
      vi_tag_nxt = stp_pkg::VI_NONE;
      vi_cnt_nxt = 6'd0;
      vi_acc_nxt = 64'd0;
      if (!vi_canon) begin
        vi_rej  = 1'b1;
        vi_code = stp_pkg::ST_NONCANON;
      end else begin
        vi_check = 1'b1;
      end
    end
    if (vi_check) begin
      if (vi_val > CNT_MAX) begin
        vi_rej  = 1'b1;
        vi_code = stp_pkg::ST_OVERSIZE;
      end else begin
        vi_done = 1'b1;
      end
    end
  end

  assign vi_cnt = COUNT_BITS'(vi_val);

  // ---------------------------------------------------------------------------
  // Phase walk
  // ---------------------------------------------------------------------------
  logic go_out_done;
  logic go_after_out;
  logic go_wit_done;
  logic go_stack_done;

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    tag_nxt      = tag_r;
    segwit_nxt   = segwit_r;
    in_total_nxt = in_total_r;
    entries_nxt  = entries_r;
    stack_nxt    = stack_r;
    payload_nxt  = payload_r;
    cursor_nxt   = cursor_r;
    err_nxt      = err_r;

    res_nxt        = '0;
    go_out_done    = 1'b0;
    go_after_out   = 1'b0;
    go_wit_done    = 1'b0;
    go_stack_done  = 1'b0;

    // After an error the rest of the buffer is dropped.
    if (err_r == stp_pkg::ST_RUNNING) begin
      if (is_varint) begin
        tag_nxt = vi_tag_nxt;
        cnt_nxt = vi_cnt_nxt;
        acc_nxt = vi_acc_nxt;
        if (vi_rej) begin
          err_nxt = vi_code;
        end
      end

      case (phase_r)
        stp_pkg::PH_VER: begin
          cnt_nxt = fix_done ? 6'd0 : cnt_r + 6'd1;
          acc_nxt = fix_done ? 64'd0 : merged;
          if (fix_done) begin
            res_nxt.valid = 1'b1;
            res_nxt.kind  = stp_pkg::KIND_VERSION;
            res_nxt.value = merged;
            phase_nxt     = stp_pkg::PH_INCNT;
          end
        end
        stp_pkg::PH_FLAG: begin
          if (in_tdata == 8'd0) begin
            err_nxt = stp_pkg::ST_ZERO_FLAG;
          end else begin
            res_nxt.valid = 1'b1;
            res_nxt.kind  = stp_pkg::KIND_FLAG;
            res_nxt.value = 64'(in_tdata);
            segwit_nxt    = 1'b1;
            phase_nxt     = stp_pkg::PH_INCNT;
          end
        end
        stp_pkg::PH_INCNT: begin
          if (vi_done) begin
            // Zero count before the flag is the segwit marker.
            if (vi_val == 64'd0 && segwit_r) begin
              err_nxt = stp_pkg::ST_ZERO_INPUTS;
            end else begin
              res_nxt.valid = 1'b1;
              res_nxt.kind  = stp_pkg::KIND_INCNT;
              res_nxt.value = vi_val;
              if (vi_val == 64'd0) begin
                phase_nxt = stp_pkg::PH_FLAG;
              end else begin
                in_total_nxt = vi_cnt;
                entries_nxt  = vi_cnt;
                cursor_nxt   = CNT_ZERO;
                phase_nxt    = stp_pkg::PH_TXID;
              end
            end
          end
        end
        stp_pkg::PH_TXID: begin
          res_nxt.valid = 1'b1;
          res_nxt.kind  = stp_pkg::KIND_TXID;
          res_nxt.value = 64'(in_tdata);
          res_nxt.index = 32'(cursor_r);
          if (cnt_r == HASH_END) begin
            cnt_nxt   = 6'd0;
            phase_nxt = stp_pkg::PH_VOUT;
          end else begin
            cnt_nxt = cnt_r + 6'd1;
          end
        end
        stp_pkg::PH_VOUT: begin
          cnt_nxt = fix_done ? 6'd0 : cnt_r + 6'd1;
          acc_nxt = fix_done ? 64'd0 : merged;
          if (fix_done) begin
            res_nxt.valid = 1'b1;
            res_nxt.kind  = stp_pkg::KIND_VOUT;
            res_nxt.value = merged;
            res_nxt.index = 32'(cursor_r);
            phase_nxt     = stp_pkg::PH_SIGLEN;
          end
        end
        stp_pkg::PH_SIGLEN: begin
          if (vi_done) begin
            res_nxt.valid = 1'b1;
            res_nxt.kind  = stp_pkg::KIND_SIGLEN;
            res_nxt.value = vi_val;
            res_nxt.index = 32'(cursor_r);
            payload_nxt   = vi_cnt;
            phase_nxt     = (vi_val != 64'd0) ? stp_pkg::PH_SIG : stp_pkg::PH_SEQ;
          end
        end
        stp_pkg::PH_SIG: begin
          res_nxt.valid = 1'b1;
          res_nxt.kind  = stp_pkg::KIND_SIGBYTE;
          res_nxt.value = 64'(in_tdata);
          res_nxt.index = 32'(cursor_r);
          payload_nxt   = payload_r - CNT_ONE;
          if (payload_r == CNT_ONE) begin
            phase_nxt = stp_pkg::PH_SEQ;
          end
        end
        stp_pkg::PH_SEQ: begin
          cnt_nxt = fix_done ? 6'd0 : cnt_r + 6'd1;
          acc_nxt = fix_done ? 64'd0 : merged;
          if (fix_done) begin
            res_nxt.valid = 1'b1;
            res_nxt.kind  = stp_pkg::KIND_SEQ;
            res_nxt.value = merged;
            res_nxt.index = 32'(cursor_r);
            entries_nxt   = entries_r - CNT_ONE;
            if (entries_r != CNT_ONE) begin
              cursor_nxt = cursor_r + CNT_ONE;
              phase_nxt  = stp_pkg::PH_TXID;
            end else begin
              cursor_nxt = CNT_ZERO;
              phase_nxt  = stp_pkg::PH_OUTCNT;
            end
          end
        end
        stp_pkg::PH_OUTCNT: begin
          if (vi_done) begin
            res_nxt.valid = 1'b1;
            res_nxt.kind  = stp_pkg::KIND_OUTCNT;
            res_nxt.value = vi_val;
            entries_nxt   = vi_cnt;
            cursor_nxt    = CNT_ZERO;
            if (vi_val != 64'd0) begin
              phase_nxt = stp_pkg::PH_VAL;
            end else begin
              go_after_out = 1'b1;
            end
          end
        end
        stp_pkg::PH_VAL: begin
          cnt_nxt = fix_done ? 6'd0 : cnt_r + 6'd1;
          acc_nxt = fix_done ? 64'd0 : merged;
          if (fix_done) begin
            res_nxt.valid = 1'b1;
            res_nxt.kind  = stp_pkg::KIND_VALUE;
            res_nxt.value = merged;
            res_nxt.index = 32'(cursor_r);
            phase_nxt     = stp_pkg::PH_SPKLEN;
          end
        end
        stp_pkg::PH_SPKLEN: begin
          if (vi_done) begin
            res_nxt.valid = 1'b1;
            res_nxt.kind  = stp_pkg::KIND_SPKLEN;
            res_nxt.value = vi_val;
            res_nxt.index = 32'(cursor_r);
            payload_nxt   = vi_cnt;
            if (vi_val != 64'd0) begin
              phase_nxt = stp_pkg::PH_SPK;
            end else begin
              go_out_done = 1'b1;
            end
          end
        end
        stp_pkg::PH_SPK: begin
          res_nxt.valid = 1'b1;
          res_nxt.kind  = stp_pkg::KIND_SPKBYTE;
          res_nxt.value = 64'(in_tdata);
          res_nxt.index = 32'(cursor_r);
          payload_nxt   = payload_r - CNT_ONE;
          go_out_done   = (payload_r == CNT_ONE);
        end
        stp_pkg::PH_WITCNT: begin
          if (vi_done) begin
            res_nxt.valid = 1'b1;
            res_nxt.kind  = stp_pkg::KIND_WITCNT;
            res_nxt.value = vi_val;
            res_nxt.index = 32'(cursor_r);
            stack_nxt     = vi_cnt;
            if (vi_val != 64'd0) begin
              phase_nxt = stp_pkg::PH_WITLEN;
            end else begin
              go_stack_done = 1'b1;
            end
          end
        end
        stp_pkg::PH_WITLEN: begin
          if (vi_done) begin
            res_nxt.valid = 1'b1;
            res_nxt.kind  = stp_pkg::KIND_WITLEN;
            res_nxt.value = vi_val;
            res_nxt.index = 32'(cursor_r);
            payload_nxt   = vi_cnt;
            if (vi_val != 64'd0) begin
              phase_nxt = stp_pkg::PH_WIT;
            end else begin
              go_wit_done = 1'b1;
            end
          end
        end
        stp_pkg::PH_WIT: begin
          res_nxt.valid = 1'b1;
          res_nxt.kind  = stp_pkg::KIND_WITBYTE;
          res_nxt.value = 64'(in_tdata);
          res_nxt.index = 32'(cursor_r);
          payload_nxt   = payload_r - CNT_ONE;
          go_wit_done   = (payload_r == CNT_ONE);
        end
        stp_pkg::PH_LOCK: begin
          cnt_nxt = fix_done ? 6'd0 : cnt_r + 6'd1;
          acc_nxt = fix_done ? 64'd0 : merged;
          if (fix_done) begin
            res_nxt.valid = 1'b1;
            res_nxt.kind  = stp_pkg::KIND_LOCKTIME;
            res_nxt.value = merged;
            phase_nxt     = stp_pkg::PH_DONE;
            if (!in_tlast) begin
              err_nxt = stp_pkg::ST_TRAILING;
            end
          end
        end
        default: begin
          // Any byte past a complete transaction is trailing data.
          err_nxt = stp_pkg::ST_TRAILING;
        end
      endcase

      // Close a witness item, then possibly its stack.
      if (go_wit_done) begin
        stack_nxt = stack_r - CNT_ONE;
        if (stack_r != CNT_ONE) begin
          phase_nxt = stp_pkg::PH_WITLEN;
        end else begin
          go_stack_done = 1'b1;
        end
      end
      if (go_stack_done) begin
        entries_nxt = entries_r - CNT_ONE;
        cursor_nxt  = cursor_r + CNT_ONE;
        phase_nxt   = (entries_r != CNT_ONE) ? stp_pkg::PH_WITCNT : stp_pkg::PH_LOCK;
      end
      // Close an output, then possibly the output list.
      if (go_out_done) begin
        entries_nxt = entries_r - CNT_ONE;
        cursor_nxt  = cursor_r + CNT_ONE;
        if (entries_r != CNT_ONE) begin
          phase_nxt = stp_pkg::PH_VAL;
        end else begin
          go_after_out = 1'b1;
        end
      end
      if (go_after_out) begin
        if (segwit_r) begin
          entries_nxt = in_total_r;
          cursor_nxt  = CNT_ZERO;
          phase_nxt   = stp_pkg::PH_WITCNT;
        end else begin
          phase_nxt = stp_pkg::PH_LOCK;
        end
      end
    end

    // Sticky error first, then end-of-buffer verdict.
    if (err_nxt != stp_pkg::ST_RUNNING) begin
      res_nxt.status = err_nxt;
    end else if (in_tlast) begin
      res_nxt.status = (phase_nxt == stp_pkg::PH_DONE) ? stp_pkg::ST_ACCEPTED
                                                       : stp_pkg::ST_TRUNCATED;
    end else begin
      res_nxt.status = stp_pkg::ST_RUNNING;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_clr) begin
      phase_r    <= stp_pkg::PH_VER;
      cnt_r      <= 6'd0;
      acc_r      <= 64'd0;
      tag_r      <= stp_pkg::VI_NONE;
      segwit_r   <= 1'b0;
      in_total_r <= CNT_ZERO;
      entries_r  <= CNT_ZERO;
      stack_r    <= CNT_ZERO;
      payload_r  <= CNT_ZERO;
      cursor_r   <= CNT_ZERO;
      err_r      <= stp_pkg::ST_RUNNING;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      acc_r      <= acc_nxt;
      tag_r      <= tag_nxt;
      segwit_r   <= segwit_nxt;
      in_total_r <= in_total_nxt;
      entries_r  <= entries_nxt;
      stack_r    <= stack_nxt;
      payload_r  <= payload_nxt;
      cursor_r   <= cursor_nxt;
      err_r      <= err_nxt;
    end
  end

  // Result register: load on each taken byte, drop once drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, res_r.status, res_r.index, res_r.value};
  assign out_tuser  = {res_r.kind, res_r.valid};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_tlast_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (phase_r == stp_pkg::PH_VER && err_r == stp_pkg::ST_RUNNING &&
                              tag_r == stp_pkg::VI_NONE && !segwit_r))
    else $error("parser state not cleared after last beat");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tlast && err_r != stp_pkg::ST_RUNNING) |=>
      (err_r == $past(err_r) && !res_r.valid && res_r.status == $past(err_r)))
    else $error("error code changed or field emitted after error");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !res_r.valid) |->
      (res_r.kind == 4'd0 && res_r.value == 64'd0 && res_r.index == 32'd0))
    else $error("non-field beat carries field content");

  a_last_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (out_tvalid && res_r.status != stp_pkg::ST_RUNNING))
    else $error("last beat left status running");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule
